FILE: sv/wue_pkg.sv
// wue_pkg: shared types, register codes and fixed-point helpers for the
// weight update engine. No dependencies; every other file imports it.
package wue_pkg;

  // fraction bits of weights, gradients, deltas and gains
  localparam int unsigned FRAC_BITS = 16;
  // fraction bits of the Q0.16 factors
  localparam int unsigned Q16_BITS = 16;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] LEARN_RATE_RESET = 32'(64'd1 << FRAC_BITS);
  localparam logic [15:0] GAIN_DOWN_RESET = 16'hffff;
  localparam logic [30:0] GAIN_MAX = 31'h7fffffff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_LEARN_RATE    = 3'd1,
    REG_MOMENTUM_GAIN = 3'd2,
    REG_DECAY_RATE    = 3'd3,
    REG_GAIN_UP       = 3'd4,
    REG_GAIN_DOWN     = 3'd5
  } cfg_idx_t;

  // update rules
  typedef enum logic [2:0] {
    MODE_PLAIN    = 3'd0,
    MODE_DECAY    = 3'd1,
    MODE_DBD      = 3'd2,
    MODE_DBD_MOM  = 3'd3,
    MODE_MOMENTUM = 3'd4,
    MODE_STORE    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] learn_rate;
    logic [15:0] momentum_gain;
    logic [15:0] decay_rate;
    logic [30:0] gain_up;
    logic [15:0] gain_down;
  } cfg_t;

  // one weight record as it travels down the pipeline
  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] grad;
    logic signed [31:0] prev_delta;
    logic [30:0]        gain;
    logic               frozen;
    logic               locked;
    logic               last;
  } item_t;

  // record plus computed delta and adapted gain
  typedef struct packed {
    item_t              item;
    logic signed [31:0] delta;
    logic [30:0]        gain_next;
  } dres_t;

  // unused codes fall back to the plain rule
  function automatic mode_t mode_norm(input logic [2:0] raw);
    case (raw)
      MODE_DECAY:    return MODE_DECAY;
      MODE_DBD:      return MODE_DBD;
      MODE_DBD_MOM:  return MODE_DBD_MOM;
      MODE_MOMENTUM: return MODE_MOMENTUM;
      MODE_STORE:    return MODE_STORE;
      default:       return MODE_PLAIN;
    endcase
  endfunction

  function automatic logic is_dbd(input mode_t m);
    return (m == MODE_DBD) || (m == MODE_DBD_MOM);
  endfunction

  function automatic logic is_mom(input mode_t m);
    return (m == MODE_DBD_MOM) || (m == MODE_MOMENTUM);
  endfunction

  function automatic logic stores_delta(input mode_t m);
    return (m == MODE_DBD) || (m == MODE_DBD_MOM) || (m == MODE_MOMENTUM) ||
           (m == MODE_STORE);
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // round to nearest with ties toward +inf, then arithmetic shift
  function automatic logic signed [65:0] rshr(input logic signed [65:0] v,
                                              input int unsigned s);
    logic signed [65:0] half;
    half = 66'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

FILE: sv/wue_cfg_regs.sv
// wue_cfg_regs: configuration register file of the weight update engine.
// Depends on wue_pkg.
module wue_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wue_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wue_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wue_pkg::cfg_t                    cfg
);
  import wue_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_PLAIN;
      cfg.learn_rate    <= LEARN_RATE_RESET;
      cfg.momentum_gain <= '0;
      cfg.decay_rate    <= '0;
      cfg.gain_up       <= '0;
      cfg.gain_down     <= GAIN_DOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:          cfg.mode          <= cfg_data[2:0];
        REG_LEARN_RATE:    cfg.learn_rate    <= cfg_data[31:0];
        REG_MOMENTUM_GAIN: cfg.momentum_gain <= cfg_data[15:0];
        REG_DECAY_RATE:    cfg.decay_rate    <= cfg_data[15:0];
        REG_GAIN_UP:       cfg.gain_up       <= cfg_data[30:0];
        REG_GAIN_DOWN:     cfg.gain_down     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/wue_delta_pipe.sv
// wue_delta_pipe: five-stage pipeline that forms the delta of one weight
// (step, dbd scaling, momentum) and adapts its gain. Depends on wue_pkg.
module wue_delta_pipe (
  input  logic            clk,
  input  logic            rst,
  input  wue_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  wue_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output wue_pkg::dres_t  out_res
);
  import wue_pkg::*;

  mode_t mode;
  logic  dbd, mom;

  assign mode = mode_norm(cfg.mode);
  assign dbd  = is_dbd(mode);
  assign mom  = is_mom(mode);

  // stage registers
  logic               s1_v, s2_v, s3_v, s4_v, s5_v;
  logic               rdy1, rdy2, rdy3, rdy4, rdy5;
  item_t              s1_item, s2_item, s3_item, s4_item, s5_item;
  logic signed [64:0] s1_p_lr;
  logic signed [48:0] s1_p_mom;
  logic [46:0]        s1_p_gain;
  logic               s1_opp, s2_opp;
  logic signed [31:0] s2_t, s3_t, s4_t2, s5_del;
  logic signed [33:0] s2_mp, s3_mp, s4_mp;
  logic [30:0]        s2_go, s3_go, s4_go, s5_go;
  logic signed [63:0] s3_p2;

  // a stage takes new data when it is empty or its contents move on
  assign rdy5     = !s5_v || out_ready;
  assign rdy4     = !s4_v || rdy5;
  assign rdy3     = !s3_v || rdy4;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;
  assign in_ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      if (rdy1) s1_v <= in_valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
      if (rdy4) s4_v <= s3_v;
      if (rdy5) s5_v <= s4_v;
    end
  end

  // stage 1: the three independent products and the sign test
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_item   <= in_item;
      s1_p_lr   <= in_item.grad * signed'({1'b0, cfg.learn_rate});
      s1_p_mom  <= in_item.prev_delta * signed'({1'b0, cfg.momentum_gain});
      s1_p_gain <= in_item.gain * cfg.gain_down;
      s1_opp    <= (in_item.prev_delta < 0 && in_item.grad > 0) ||
                   (in_item.prev_delta > 0 && in_item.grad < 0);
    end
  end

  // stage 2: round the step and the momentum term, adapt the gain
  logic signed [65:0] mp_wide;
  logic [47:0]        gdown_sum;
  logic [31:0]        gup_sum;
  logic [30:0]        go_next;

  always_comb begin
    mp_wide   = rshr(66'(s1_p_mom), Q16_BITS);
    gdown_sum = {1'b0, s1_p_gain} + 48'd32768;
    gup_sum   = {1'b0, s1_item.gain} + {1'b0, cfg.gain_up};
    if (!dbd || s1_item.locked) begin
      go_next = s1_item.gain;
    end else if (s1_opp) begin
      go_next = gdown_sum[46:16];
    end else if (gup_sum[31]) begin
      go_next = GAIN_MAX;
    end else begin
      go_next = gup_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_item <= s1_item;
      s2_t    <= sat32(rshr(66'(s1_p_lr), FRAC_BITS));
      s2_mp   <= mp_wide[33:0];
      s2_go   <= go_next;
      s2_opp  <= s1_opp;
    end
  end

  // stage 3: step times per-weight gain
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_item <= s2_item;
      s3_p2   <= s2_t * signed'({1'b0, s2_item.gain});
      s3_t    <= s2_t;
      s3_mp   <= s2_mp;
      s3_go   <= s2_go;
    end
  end

  // stage 4: round the gain-scaled step in dbd modes
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_item <= s3_item;
      s4_t2   <= dbd ? sat32(rshr(66'(s3_p2), FRAC_BITS)) : s3_t;
      s4_mp   <= s3_mp;
      s4_go   <= s3_go;
    end
  end

  // stage 5: add momentum, frozen weights get no delta
  logic signed [31:0] del_next;

  always_comb begin
    if (s4_item.frozen) begin
      del_next = '0;
    end else if (mom) begin
      del_next = sat32(66'(s4_t2) + 66'(s4_mp));
    end else begin
      del_next = s4_t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_item <= s4_item;
      s5_del  <= del_next;
      s5_go   <= s4_go;
    end
  end

  assign out_valid         = s5_v;
  assign out_res.item      = s5_item;
  assign out_res.delta     = s5_del;
  assign out_res.gain_next = s5_go;

  // a stalled first stage keeps its step product and its record
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && !rdy2 |=> s1_v && $stable(s1_p_lr) && $stable(s1_item))
    else $error("stage 1 contents changed while stalled");

  // opposite signs in dbd modes never raise the gain
  a_gain_down: assert property (@(posedge clk) disable iff (rst)
    s2_v && s2_opp && dbd && !s2_item.locked |-> s2_go <= s2_item.gain)
    else $error("gain grew on a sign change");

  // frozen weights leave with a zero delta
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    s5_v && s5_item.frozen |-> s5_del == '0)
    else $error("frozen weight carries a delta");

endmodule

FILE: sv/wue_apply_pipe.sv
// wue_apply_pipe: three-stage pipeline that applies the delta, scales the
// weight in decay mode and builds the output record. Depends on wue_pkg.
module wue_apply_pipe (
  input  logic                clk,
  input  logic                rst,
  input  wue_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  wue_pkg::dres_t      in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  weight_out,
  output logic signed [31:0]  prev_delta_out,
  output logic [30:0]         gain_out,
  output logic signed [31:0]  grad_out,
  output logic                last_out
);
  import wue_pkg::*;

  mode_t mode;
  assign mode = mode_norm(cfg.mode);

  logic               s6_v, s7_v, s8_v;
  logic               rdy6, rdy7, rdy8;
  dres_t              s6_res, s7_res;
  logic signed [31:0] s6_wo, s7_wo;
  logic signed [49:0] s7_pd;
  logic               s8_locked;
  logic [16:0]        scale;

  assign rdy8     = !s8_v || out_ready;
  assign rdy7     = !s7_v || rdy8;
  assign rdy6     = !s6_v || rdy7;
  assign in_ready = rdy6;

  // weight is scaled by one minus the decay fraction
  assign scale = 17'h10000 - {1'b0, cfg.decay_rate};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
    end else begin
      if (rdy6) s6_v <= in_valid;
      if (rdy7) s7_v <= s6_v;
      if (rdy8) s8_v <= s7_v;
    end
  end

  // stage 6: subtract the delta
  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_res <= in_res;
      s6_wo  <= sat32(66'(in_res.item.weight) - 66'(in_res.delta));
    end
  end

  // stage 7: decay product
  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_res <= s6_res;
      s7_wo  <= s6_wo;
      s7_pd  <= s6_wo * signed'({1'b0, scale});
    end
  end

  // stage 8: output register, locked records pass untouched
  logic signed [31:0] wo_final;

  always_comb begin
    if (s7_res.item.locked) begin
      wo_final = s7_res.item.weight;
    end else if (mode == MODE_DECAY && !s7_res.item.frozen) begin
      wo_final = sat32(rshr(66'(s7_pd), Q16_BITS));
    end else begin
      wo_final = s7_wo;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy8) begin
      weight_out     <= wo_final;
      prev_delta_out <= (!s7_res.item.locked && stores_delta(mode)) ?
                        s7_res.delta : s7_res.item.prev_delta;
      gain_out       <= s7_res.gain_next;
      grad_out       <= s7_res.item.locked ? s7_res.item.grad : '0;
      last_out       <= s7_res.item.last;
      s8_locked      <= s7_res.item.locked;
    end
  end

  assign out_valid = s8_v;

  // a stalled apply stage keeps its weight
  a_s6_hold: assert property (@(posedge clk) disable iff (rst)
    s6_v && !rdy7 |=> s6_v && $stable(s6_wo))
    else $error("stage 6 weight changed while stalled");

  // gradient write-back is cleared unless the record is locked
  a_grad_clear: assert property (@(posedge clk) disable iff (rst)
    s8_v && !s8_locked |-> grad_out == '0)
    else $error("gradient write-back not cleared");

  // a stalled output keeps its weight and gradient write-back
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_out) && $stable(grad_out))
    else $error("output transaction changed while stalled");

endmodule

FILE: sv/weight_update_engine_top.sv
// weight_update_engine_top: per-weight optimizer update in fixed point.
// Depends on wue_pkg, wue_cfg_regs, wue_delta_pipe and wue_apply_pipe.
//
//   channel   handshake             payload
//   input     in_valid / in_stall   weight_in grad_in frozen_in prev_delta_in
//                                   gain_in locked_in last_in_block
//   output    out_valid / out_stall weight_out prev_delta_out gain_out
//                                   grad_out last_out
//   config    cfg_valid / cfg_ready cfg_index cfg_data
//
// one weight enters per cycle while in_stall is low; its result passes through
// stages s1 to s8 and is held in the output register while out_stall is high
// eight register stages: three multiply stages, three rounding stages
// rst is synchronous and clears all valid bits and the configuration
// a stall backs up only into stages that hold data, so bubbles are squeezed
// out and in_stall rises only once every stage is full
module weight_update_engine_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              weight_in,
  input  logic signed [31:0]              grad_in,
  input  logic                            frozen_in,
  input  logic signed [31:0]              prev_delta_in,
  input  logic [30:0]                     gain_in,
  input  logic                            locked_in,
  input  logic                            last_in_block,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              weight_out,
  output logic signed [31:0]              prev_delta_out,
  output logic [30:0]                     gain_out,
  output logic signed [31:0]              grad_out,
  output logic                            last_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wue_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wue_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wue_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  dres_t mid_res;
  logic  in_ready, mid_valid, mid_ready;

  // configuration registers
  wue_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pack the input transaction
  assign in_item.weight     = weight_in;
  assign in_item.grad       = grad_in;
  assign in_item.prev_delta = prev_delta_in;
  assign in_item.gain       = gain_in;
  assign in_item.frozen     = frozen_in;
  assign in_item.locked     = locked_in;
  assign in_item.last       = last_in_block;
  assign in_stall           = !in_ready;

  // delta and gain pipeline
  wue_delta_pipe u_delta (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_res   (mid_res)
  );

  // weight apply and output stage
  wue_apply_pipe u_apply (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (mid_valid),
    .in_ready       (mid_ready),
    .in_res         (mid_res),
    .out_valid      (out_valid),
    .out_ready      (!out_stall),
    .weight_out     (weight_out),
    .prev_delta_out (prev_delta_out),
    .gain_out       (gain_out),
    .grad_out       (grad_out),
    .last_out       (last_out)
  );

endmodule
